/* sv/fpsa_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and tables for the flash plane striping address unit.
// No dependencies; every other file of the block imports this package.

package fpsa_pkg;

    localparam int ADDR_W      = 32;
    localparam int NUM_UNITS   = 4;
    localparam int UNIT_W      = 2;
    localparam int CNT_W       = 5;
    localparam int DIGIT_W     = 4;
    localparam int REM_W       = CNT_W + 1;
    localparam int SCHEME_W    = 5;
    localparam int NUM_SCHEMES = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 5;
    localparam int NARROW_W    = 4;
    localparam int MAX_COUNT   = 16;

    typedef logic [UNIT_W-1:0] t_unit;
    typedef logic [NUM_UNITS-1:0][DIGIT_W-1:0] t_digits;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [ADDR_W-1:0] recip;
    } t_divisor;

    localparam t_unit UNIT_CHANNEL = 2'd0;
    localparam t_unit UNIT_CHIP    = 2'd1;
    localparam t_unit UNIT_DIE     = 2'd2;
    localparam t_unit UNIT_PLANE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SCHEME        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHIP_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIE_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT   = 3'd4;

    localparam logic [CNT_W-1:0] MAX_CHANNELS = 5'd16;
    localparam logic [CNT_W-1:0] MAX_CHIPS    = 5'd16;
    localparam logic [CNT_W-1:0] MAX_DIES     = 5'd8;
    localparam logic [CNT_W-1:0] MAX_PLANES   = 5'd8;

    localparam logic [SCHEME_W-1:0] SCHEME_RESET        = 5'd0;
    localparam logic [CNT_W-1:0]    CHANNEL_COUNT_RESET = 5'd16;
    localparam logic [CNT_W-1:0]    CHIP_COUNT_RESET    = 5'd16;
    localparam logic [NARROW_W-1:0] DIE_COUNT_RESET     = 4'd8;
    localparam logic [NARROW_W-1:0] PLANE_COUNT_RESET   = 4'd8;

    localparam logic [ADDR_W-1:0] ALL_ONES = '1;

    // floor((2^ADDR_W - 1) / c): the estimated quotient is low by at most one.
    localparam logic [ADDR_W-1:0] RECIP_TABLE [MAX_COUNT+1] = '{
        ALL_ONES,      ALL_ONES / 1,  ALL_ONES / 2,  ALL_ONES / 3,
        ALL_ONES / 4,  ALL_ONES / 5,  ALL_ONES / 6,  ALL_ONES / 7,
        ALL_ONES / 8,  ALL_ONES / 9,  ALL_ONES / 10, ALL_ONES / 11,
        ALL_ONES / 12, ALL_ONES / 13, ALL_ONES / 14, ALL_ONES / 15,
        ALL_ONES / 16
    };

    // Unit order per scheme; the first unit takes the least significant digit.
    localparam t_unit ORDER_TABLE [NUM_SCHEMES][NUM_UNITS] = '{
        '{UNIT_CHANNEL, UNIT_CHIP,    UNIT_DIE,     UNIT_PLANE},
        '{UNIT_CHANNEL, UNIT_CHIP,    UNIT_PLANE,   UNIT_DIE},
        '{UNIT_CHANNEL, UNIT_DIE,     UNIT_CHIP,    UNIT_PLANE},
        '{UNIT_CHANNEL, UNIT_DIE,     UNIT_PLANE,   UNIT_CHIP},
        '{UNIT_CHANNEL, UNIT_PLANE,   UNIT_CHIP,    UNIT_DIE},
        '{UNIT_CHANNEL, UNIT_PLANE,   UNIT_DIE,     UNIT_CHIP},
        '{UNIT_CHIP,    UNIT_CHANNEL, UNIT_DIE,     UNIT_PLANE},
        '{UNIT_CHIP,    UNIT_CHANNEL, UNIT_PLANE,   UNIT_DIE},
        '{UNIT_CHIP,    UNIT_DIE,     UNIT_CHANNEL, UNIT_PLANE},
        '{UNIT_CHIP,    UNIT_DIE,     UNIT_PLANE,   UNIT_CHANNEL},
        '{UNIT_CHIP,    UNIT_PLANE,   UNIT_CHANNEL, UNIT_DIE},
        '{UNIT_CHIP,    UNIT_PLANE,   UNIT_DIE,     UNIT_CHANNEL},
        '{UNIT_DIE,     UNIT_CHANNEL, UNIT_CHIP,    UNIT_PLANE},
        '{UNIT_DIE,     UNIT_CHANNEL, UNIT_PLANE,   UNIT_CHIP},
        '{UNIT_DIE,     UNIT_CHIP,    UNIT_CHANNEL, UNIT_PLANE},
        '{UNIT_DIE,     UNIT_CHIP,    UNIT_PLANE,   UNIT_CHANNEL},
        '{UNIT_DIE,     UNIT_PLANE,   UNIT_CHANNEL, UNIT_CHIP},
        '{UNIT_DIE,     UNIT_PLANE,   UNIT_CHIP,    UNIT_CHANNEL},
        '{UNIT_PLANE,   UNIT_CHANNEL, UNIT_CHIP,    UNIT_DIE},
        '{UNIT_PLANE,   UNIT_CHANNEL, UNIT_DIE,     UNIT_CHIP},
        '{UNIT_PLANE,   UNIT_CHIP,    UNIT_CHANNEL, UNIT_DIE},
        '{UNIT_PLANE,   UNIT_CHIP,    UNIT_DIE,     UNIT_CHANNEL},
        '{UNIT_PLANE,   UNIT_DIE,     UNIT_CHANNEL, UNIT_CHIP},
        '{UNIT_PLANE,   UNIT_DIE,     UNIT_CHIP,    UNIT_CHANNEL}
    };

    // A zero count means one member; counts above the maximum saturate.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                    input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] res;
        if (c == '0) begin
            res = {{(CNT_W-1){1'b0}}, 1'b1};
        end else if (c > maxv) begin
            res = maxv;
        end else begin
            res = c;
        end
        return res;
    endfunction

endpackage

/* sv/fpsa_cfg.sv */
`timescale 1ns / 1ps
// Configuration registers and the per-position divisor table derived from them.
// Depends on fpsa_pkg.

module fpsa_cfg
    import fpsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_divisor              o_div  [NUM_UNITS],
    output t_unit                 o_unit [NUM_UNITS]
);

    logic [SCHEME_W-1:0] r_scheme,        n_scheme;
    logic [CNT_W-1:0]    r_channel_count, n_channel_count;
    logic [CNT_W-1:0]    r_chip_count,    n_chip_count;
    logic [NARROW_W-1:0] r_die_count,     n_die_count;
    logic [NARROW_W-1:0] r_plane_count,   n_plane_count;
    t_divisor            r_pos_div  [NUM_UNITS];
    t_divisor            n_pos_div  [NUM_UNITS];
    t_unit               r_pos_unit [NUM_UNITS];
    t_unit               n_pos_unit [NUM_UNITS];
    logic [SCHEME_W-1:0] sel;
    logic [CNT_W-1:0]    clamped [NUM_UNITS];

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_scheme        = r_scheme;
        n_channel_count = r_channel_count;
        n_chip_count    = r_chip_count;
        n_die_count     = r_die_count;
        n_plane_count   = r_plane_count;
        if (!i_rst_n) begin
            n_scheme        = SCHEME_RESET;
            n_channel_count = CHANNEL_COUNT_RESET;
            n_chip_count    = CHIP_COUNT_RESET;
            n_die_count     = DIE_COUNT_RESET;
            n_plane_count   = PLANE_COUNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCHEME:        n_scheme        = i_cfg_data;
                REG_CHANNEL_COUNT: n_channel_count = i_cfg_data;
                REG_CHIP_COUNT:    n_chip_count    = i_cfg_data;
                REG_DIE_COUNT:     n_die_count     = i_cfg_data[NARROW_W-1:0];
                REG_PLANE_COUNT:   n_plane_count   = i_cfg_data[NARROW_W-1:0];
                default: ;
            endcase
        end
    end

    // The divisor table follows the next register values, so it is current
    // at the same edge as the registers themselves.
    always_comb begin
        sel = (n_scheme < SCHEME_W'(NUM_SCHEMES)) ? n_scheme : '0;
        clamped[UNIT_CHANNEL] = clamp_count(n_channel_count, MAX_CHANNELS);
        clamped[UNIT_CHIP]    = clamp_count(n_chip_count, MAX_CHIPS);
        clamped[UNIT_DIE]     = clamp_count({1'b0, n_die_count}, MAX_DIES);
        clamped[UNIT_PLANE]   = clamp_count({1'b0, n_plane_count}, MAX_PLANES);
        for (int k = 0; k < NUM_UNITS; k++) begin
            n_pos_unit[k]      = ORDER_TABLE[sel][k];
            n_pos_div[k].count = clamped[ORDER_TABLE[sel][k]];
            n_pos_div[k].recip = RECIP_TABLE[clamped[ORDER_TABLE[sel][k]]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_scheme        <= n_scheme;
        r_channel_count <= n_channel_count;
        r_chip_count    <= n_chip_count;
        r_die_count     <= n_die_count;
        r_plane_count   <= n_plane_count;
        r_pos_div       <= n_pos_div;
        r_pos_unit      <= n_pos_unit;
    end

    assign o_div  = r_pos_div;
    assign o_unit = r_pos_unit;

endmodule

/* sv/fpsa_div_stage.sv */
`timescale 1ns / 1ps
// One mixed-radix digit: divides the running page by a small count in two
// register stages (reciprocal multiply, then remainder and correction). Uses fpsa_pkg.

module fpsa_div_stage
    import fpsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_divisor          i_div,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ADDR_W-1:0] i_page,
    input  t_digits           i_digits,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_page,
    output t_digits           o_digits
);

    logic                r_a_valid;
    logic [ADDR_W-1:0]   r_a_page;
    logic [ADDR_W-1:0]   r_a_qest;
    t_digits             r_a_digits;
    logic                r_b_valid;
    logic [ADDR_W-1:0]   r_b_page;
    t_digits             r_b_digits;
    logic                a_ready;
    logic                b_ready;
    logic [2*ADDR_W-1:0] product;
    logic [REM_W-1:0]    qc_low;
    logic [REM_W-1:0]    rem_est;
    logic [REM_W-1:0]    rem;
    logic [ADDR_W-1:0]   quot;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    assign product = i_page * i_div.recip;

    // The remainder is below twice the count, so its low bits are exact.
    always_comb begin
        qc_low  = REM_W'(r_a_qest[REM_W-1:0] * i_div.count);
        rem_est = r_a_page[REM_W-1:0] - qc_low;
        if (rem_est >= {1'b0, i_div.count}) begin
            rem  = rem_est - {1'b0, i_div.count};
            quot = r_a_qest + ADDR_W'(1);
        end else begin
            rem  = rem_est;
            quot = r_a_qest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_page   <= i_page;
            r_a_qest   <= product[2*ADDR_W-1:ADDR_W];
            r_a_digits <= i_digits;
        end
        if (b_ready && r_a_valid) begin
            r_b_page   <= quot;
            r_b_digits <= {rem[DIGIT_W-1:0], r_a_digits[NUM_UNITS-1:1]};
        end
    end

    assign o_valid  = r_b_valid;
    assign o_page   = r_b_page;
    assign o_digits = r_b_digits;

endmodule

/* sv/flash_plane_striping_address_unit.sv */
`timescale 1ns / 1ps
// Top level of the flash plane striping address unit: configuration block,
// four digit stages and the output register. Depends on fpsa_pkg, fpsa_cfg, fpsa_div_stage.

// Usage:
// A logical page enters on the input channel (i_in_valid, o_in_stall) and is
// split into channel, chip, die and plane indexes, which leave on the output
// channel (o_out_valid, i_out_stall). A transfer happens when valid is high
// and stall is low. The unit order and the four counts come from the
// configuration channel (i_cfg_valid, o_cfg_ready, index and data); ready is
// always high, and registers must only be written while no page is in flight.
// Each of the four digits takes two register stages: a 32 by 32 reciprocal
// multiply, then the remainder with a one-step correction. With the output
// register the pipeline is nine stages deep, and one page per cycle is
// sustained while the output is not stalled.
// A stall on the output holds the output register; the stages behind it keep
// filling until each holds a page, and only then is the input stalled.
// Reset empties the pipeline and loads the default configuration: unit order
// channel-chip-die-plane with 16 channels, 16 chips, 8 dies and 8 planes.

module flash_plane_striping_address_unit
    import fpsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ADDR_W-1:0]     i_logical_page,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [3:0]            o_channel_index,
    output logic [3:0]            o_chip_index,
    output logic [2:0]            o_die_index,
    output logic [2:0]            o_plane_index
);

    t_divisor             w_div  [NUM_UNITS];
    t_unit                w_unit [NUM_UNITS];
    logic [NUM_UNITS:0]   w_valid;
    logic [NUM_UNITS:0]   w_ready;
    logic [ADDR_W-1:0]    w_page   [NUM_UNITS+1];
    t_digits              w_digits [NUM_UNITS+1];
    logic [DIGIT_W-1:0]   unit_idx [NUM_UNITS];
    logic                 r_out_valid;
    logic [DIGIT_W-1:0]   r_channel_index;
    logic [DIGIT_W-1:0]   r_chip_index;
    logic [DIGIT_W-1:0]   r_die_index;
    logic [DIGIT_W-1:0]   r_plane_index;
    logic                 out_ready;

    fpsa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_div       (w_div),
        .o_unit      (w_unit)
    );

    assign w_valid[0]  = i_in_valid;
    assign o_in_stall  = !w_ready[0];
    assign w_page[0]   = i_logical_page;
    assign w_digits[0] = '0;

    for (genvar g = 0; g < NUM_UNITS; g++) begin : g_digit
        fpsa_div_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_div    (w_div[g]),
            .i_valid  (w_valid[g]),
            .o_ready  (w_ready[g]),
            .i_page   (w_page[g]),
            .i_digits (w_digits[g]),
            .o_valid  (w_valid[g+1]),
            .i_ready  (w_ready[g+1]),
            .o_page   (w_page[g+1]),
            .o_digits (w_digits[g+1])
        );
    end

    assign out_ready          = !r_out_valid || !i_out_stall;
    assign w_ready[NUM_UNITS] = out_ready;

    // Digits arrive in striping order; route each to the unit it belongs to.
    always_comb begin
        for (int u = 0; u < NUM_UNITS; u++) begin
            unit_idx[u] = '0;
        end
        for (int k = 0; k < NUM_UNITS; k++) begin
            unit_idx[w_unit[k]] = w_digits[NUM_UNITS][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= w_valid[NUM_UNITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && w_valid[NUM_UNITS]) begin
            r_channel_index <= unit_idx[UNIT_CHANNEL];
            r_chip_index    <= unit_idx[UNIT_CHIP];
            r_die_index     <= unit_idx[UNIT_DIE];
            r_plane_index   <= unit_idx[UNIT_PLANE];
        end
    end

    // The final quotient is not needed; it only marks the end of the chain.
    logic unused_quot;
    assign unused_quot = ^w_page[NUM_UNITS];

    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_channel_index;
    assign o_chip_index    = r_chip_index;
    assign o_die_index     = r_die_index[2:0];
    assign o_plane_index   = r_plane_index[2:0];

endmodule
